/* hdl/i2crm_pkg.sv */
// i2crm_pkg: shared types and constants for the I2C register master.
// Holds the request layout, the action and sequencer stage codes, reset values.
// No dependencies.
package i2crm_pkg;

	localparam int BUF_DEPTH     = 256;
	localparam int IN_DATA_W     = 40;
	localparam int IN_USER_W     = 2;
	localparam int OUT_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 8;
	localparam int DEV_ADDR_W    = 7;
	localparam int BYTE_W        = 8;
	localparam int REG_ADDR_W    = 16;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEV_ADDR    = 1'b0,
		CFG_ACK_TIMEOUT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		STG_IDLE   = 3'd0,
		STG_START  = 3'd1,
		STG_ADDR_W = 3'd2,
		STG_REG_HI = 3'd3,
		STG_REG_LO = 3'd4,
		STG_ADDR_R = 3'd5,
		STG_DATA_W = 3'd6,
		STG_RECV   = 3'd7
	} stage_t;

endpackage

/* hdl/i2crm_ram.sv */
// i2crm_ram: generic single-port-write, single-port-read RAM, registered read.
// Used for the write data buffer. Depends on nothing.
module i2crm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/i2c_register_master.sv */
// i2c_register_master: I2C master for targets with 16-bit register addresses.
// Depends on i2crm_pkg and i2crm_ram.
//
// Usage: each request on the s_axis channel carries an action in tuser:
// tick (one bus phase), load a write byte, begin a write or begin a read.
// Loads and begins are taken only while no transaction runs; a tick while idle
// changes nothing. Every request yields exactly one result on m_axis with the
// SCL/SDA levels, busy, done and error flags; read bytes come with tuser high
// and tlast marks the final byte of a read.
// The result is registered on the edge that accepts the request. One request
// per cycle is sustained; the result register frees itself in the same cycle
// it is taken, so s_axis_tready is low only while a result waits and
// m_axis_tready is low.
// The write bytes sit in a buffer RAM with registered read; its address is the
// next byte to send, so the data is ready long before the acknowledge arrives.
// Configuration writes (device address, ack timeout) take effect at once; the
// user must make them while no transaction runs, as the block does not enforce it.
// Reset: idle, lines released high, ack timeout 250, buffer contents undefined.
module i2c_register_master #(
	parameter int BUFFER_DEPTH = i2crm_pkg::BUF_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sda_in[0], reg_address[16:1], byte_count[24:17], write_byte[32:25]
	input  logic [i2crm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// action[1:0]
	input  logic [i2crm_pkg::IN_USER_W-1:0]     s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// scl_out[0], sda_out[1], busy_res[2], read_byte[10:3], done_res[11], error[12]
	output logic [i2crm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// read_valid[0]
	output logic [0:0]                          m_axis_tuser,
	output logic                                m_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_we,
	input  logic [i2crm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2crm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);
	localparam logic [AW-1:0] PTR_SECOND = AW'(1 % BUFFER_DEPTH);

	// request fields
	i2crm_pkg::action_t action;
	logic        sda_in;
	logic [15:0] reg_address;
	logic [7:0]  byte_count;
	logic [7:0]  write_byte;
	logic        in_fire;

	assign action      = i2crm_pkg::action_t'(s_axis_tuser);
	assign sda_in      = s_axis_tdata[0];
	assign reg_address = s_axis_tdata[16:1];
	assign byte_count  = s_axis_tdata[24:17];
	assign write_byte  = s_axis_tdata[32:25];
	assign in_fire     = s_axis_tvalid && s_axis_tready;

	// configuration
	logic [6:0] dev_addr_q;
	logic [7:0] ack_tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= '0;
			ack_tmo_q  <= i2crm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (i2crm_pkg::cfg_reg_t'(cfg_index))
				i2crm_pkg::CFG_DEV_ADDR:    dev_addr_q <= cfg_data[6:0];
				i2crm_pkg::CFG_ACK_TIMEOUT: ack_tmo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	i2crm_pkg::stage_t stage_q, stage_nx;
	logic [2:0]    step_q, step_nx;
	logic [2:0]    bit_q, bit_nx;
	logic [7:0]    bcnt_q, bcnt_nx;
	logic [7:0]    shift_q, shift_nx;
	logic [7:0]    ackw_q, ackw_nx;
	logic [AW-1:0] lptr_q, lptr_nx;
	logic [AW-1:0] rptr_q, rptr_nx;
	logic [15:0]   held_q, held_nx;
	logic [7:0]    len_q, len_nx;
	logic          rmode_q, rmode_nx;
	logic          err_q, err_nx;
	logic          scl_q, scl_nx;
	logic          sda_q, sda_nx;

	// result
	logic       r_valid, r_last, r_done, r_err;
	logic [7:0] r_byte;
	logic       ram_we;
	logic [7:0] ram_rdata;
	logic       idle;
	logic       last;
	logic [7:0] bcnt_inc;
	logic [7:0] shift_in;

	logic                                m_valid_q;
	logic [i2crm_pkg::OUT_DATA_W-1:0]    m_data_q;
	logic                                m_user_q;
	logic                                m_last_q;

	assign idle     = (stage_q == i2crm_pkg::STG_IDLE) && (step_q == 3'd0);
	assign last     = ({1'b0, bcnt_q} + 9'd1) >= {1'b0, len_q};
	assign bcnt_inc = bcnt_q + 8'd1;
	assign shift_in = {shift_q[6:0], sda_in};

	i2crm_ram #(
		.WIDTH (i2crm_pkg::BYTE_W),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (lptr_q),
		.wdata (write_byte),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		stage_nx = stage_q;
		step_nx  = step_q;
		bit_nx   = bit_q;
		bcnt_nx  = bcnt_q;
		shift_nx = shift_q;
		ackw_nx  = ackw_q;
		lptr_nx  = lptr_q;
		rptr_nx  = rptr_q;
		held_nx  = held_q;
		len_nx   = len_q;
		rmode_nx = rmode_q;
		err_nx   = err_q;
		scl_nx   = scl_q;
		sda_nx   = sda_q;
		r_valid  = 1'b0;
		r_last   = 1'b0;
		r_done   = 1'b0;
		r_err    = 1'b0;
		r_byte   = '0;
		ram_we   = 1'b0;

		if (action == i2crm_pkg::ACT_TICK) begin
			unique case (stage_q)
				i2crm_pkg::STG_IDLE: begin
					unique case (step_q)
						3'd1: begin
							scl_nx = 1'b0; sda_nx = 1'b0; step_nx = 3'd2;
						end
						3'd2: begin
							scl_nx = 1'b1; sda_nx = 1'b0; step_nx = 3'd3;
						end
						3'd3: begin
							scl_nx  = 1'b1; sda_nx = 1'b1; step_nx = 3'd0;
							lptr_nx = '0;
							r_done  = 1'b1;
							r_err   = err_q;
						end
						default: step_nx = 3'd0;
					endcase
				end
				i2crm_pkg::STG_START: begin
					unique case (step_q)
						3'd0: begin
							scl_nx = 1'b0; sda_nx = 1'b1; step_nx = 3'd1;
						end
						3'd1: begin
							scl_nx = 1'b1; sda_nx = 1'b1; step_nx = 3'd2;
						end
						3'd2: begin
							scl_nx = 1'b1; sda_nx = 1'b0; step_nx = 3'd3;
						end
						3'd3: begin
							scl_nx   = 1'b0; sda_nx = 1'b0;
							stage_nx = i2crm_pkg::STG_ADDR_R; step_nx = 3'd0;
							shift_nx = {dev_addr_q, 1'b1}; bit_nx = 3'd0;
						end
						3'd4: begin
							scl_nx = 1'b1; sda_nx = 1'b0; step_nx = 3'd5;
						end
						3'd5: begin
							scl_nx   = 1'b0; sda_nx = 1'b0;
							stage_nx = i2crm_pkg::STG_ADDR_W; step_nx = 3'd0;
							shift_nx = {dev_addr_q, 1'b0}; bit_nx = 3'd0;
						end
						default: begin
							stage_nx = i2crm_pkg::STG_IDLE; step_nx = 3'd1;
						end
					endcase
				end
				i2crm_pkg::STG_RECV: begin
					unique case (step_q)
						3'd0: begin
							scl_nx = 1'b1; sda_nx = 1'b1; step_nx = 3'd1;
						end
						3'd1: begin
							scl_nx   = 1'b0; sda_nx = 1'b1;
							shift_nx = shift_in;
							if (bit_q == 3'd7) begin
								bit_nx  = 3'd0;
								r_byte  = shift_in;
								r_valid = 1'b1;
								r_last  = last;
								step_nx = 3'd2;
							end else begin
								bit_nx  = bit_q + 3'd1;
								step_nx = 3'd0;
							end
						end
						3'd2: begin
							scl_nx = 1'b0; sda_nx = last; step_nx = 3'd3;
						end
						3'd3: begin
							scl_nx = 1'b1; sda_nx = last; step_nx = 3'd4;
						end
						3'd4: begin
							scl_nx = 1'b0; sda_nx = last;
							if (last) begin
								stage_nx = i2crm_pkg::STG_IDLE; step_nx = 3'd1;
							end else begin
								step_nx = 3'd5;
							end
						end
						3'd5: begin
							scl_nx   = 1'b0; sda_nx = 1'b1;
							bcnt_nx  = bcnt_inc;
							shift_nx = '0; bit_nx = 3'd0; step_nx = 3'd0;
						end
						default: begin
							stage_nx = i2crm_pkg::STG_IDLE; step_nx = 3'd1;
						end
					endcase
				end
				default: begin
					// byte transmit and ack stages
					unique case (step_q)
						3'd0: begin
							scl_nx = 1'b0; sda_nx = shift_q[7]; step_nx = 3'd1;
						end
						3'd1: begin
							scl_nx = 1'b1; sda_nx = shift_q[7];
							if (bit_q == 3'd7) begin
								bit_nx = 3'd0; step_nx = 3'd2;
							end else begin
								bit_nx   = bit_q + 3'd1;
								shift_nx = {shift_q[6:0], 1'b0};
								step_nx  = 3'd0;
							end
						end
						3'd2: begin
							scl_nx = 1'b0; sda_nx = 1'b1; step_nx = 3'd3;
						end
						3'd3: begin
							scl_nx  = 1'b1; sda_nx = 1'b1;
							ackw_nx = '0; step_nx = 3'd4;
						end
						3'd4: begin
							if (!sda_in) begin
								scl_nx = 1'b0; sda_nx = 1'b1;
								step_nx = 3'd0;
								bit_nx  = 3'd0;
								unique case (stage_q)
									i2crm_pkg::STG_ADDR_W: begin
										stage_nx = i2crm_pkg::STG_REG_HI;
										shift_nx = held_q[15:8];
									end
									i2crm_pkg::STG_REG_HI: begin
										stage_nx = i2crm_pkg::STG_REG_LO;
										shift_nx = held_q[7:0];
									end
									i2crm_pkg::STG_REG_LO: begin
										bcnt_nx = '0;
										if (rmode_q) begin
											stage_nx = i2crm_pkg::STG_START;
										end else if (len_q == 8'd0) begin
											stage_nx = i2crm_pkg::STG_IDLE;
											step_nx  = 3'd1;
										end else begin
											stage_nx = i2crm_pkg::STG_DATA_W;
											shift_nx = ram_rdata;
											rptr_nx  = PTR_SECOND;
										end
									end
									i2crm_pkg::STG_ADDR_R: begin
										stage_nx = i2crm_pkg::STG_RECV;
										shift_nx = '0;
										bcnt_nx  = '0;
									end
									default: begin
										bcnt_nx = bcnt_inc;
										if (bcnt_inc >= len_q) begin
											stage_nx = i2crm_pkg::STG_IDLE;
											step_nx  = 3'd1;
										end else begin
											stage_nx = i2crm_pkg::STG_DATA_W;
											shift_nx = ram_rdata;
											rptr_nx  = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
										end
									end
								endcase
							end else if (ackw_q >= ack_tmo_q) begin
								scl_nx   = 1'b0; sda_nx = 1'b1;
								err_nx   = 1'b1;
								stage_nx = i2crm_pkg::STG_IDLE; step_nx = 3'd1;
							end else begin
								ackw_nx = ackw_q + 8'd1;
								scl_nx  = 1'b1; sda_nx = 1'b1;
							end
						end
						default: begin
							stage_nx = i2crm_pkg::STG_IDLE; step_nx = 3'd1;
						end
					endcase
				end
			endcase
		end else if (idle) begin
			if (action == i2crm_pkg::ACT_LOAD) begin
				ram_we  = in_fire;
				lptr_nx = (lptr_q == PTR_LAST) ? '0 : lptr_q + 1'b1;
			end else begin
				held_nx  = reg_address;
				rmode_nx = (action == i2crm_pkg::ACT_READ);
				len_nx   = ((action == i2crm_pkg::ACT_READ) && (byte_count == 8'd0)) ?
				           8'd1 : byte_count;
				err_nx   = 1'b0;
				bcnt_nx  = '0;
				bit_nx   = 3'd0;
				ackw_nx  = '0;
				rptr_nx  = '0;
				stage_nx = i2crm_pkg::STG_START;
				step_nx  = 3'd4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= i2crm_pkg::STG_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			bcnt_q  <= '0;
			shift_q <= '0;
			ackw_q  <= '0;
			lptr_q  <= '0;
			rptr_q  <= '0;
			held_q  <= '0;
			len_q   <= '0;
			rmode_q <= 1'b0;
			err_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (in_fire) begin
			stage_q <= stage_nx;
			step_q  <= step_nx;
			bit_q   <= bit_nx;
			bcnt_q  <= bcnt_nx;
			shift_q <= shift_nx;
			ackw_q  <= ackw_nx;
			lptr_q  <= lptr_nx;
			rptr_q  <= rptr_nx;
			held_q  <= held_nx;
			len_q   <= len_nx;
			rmode_q <= rmode_nx;
			err_q   <= err_nx;
			scl_q   <= scl_nx;
			sda_q   <= sda_nx;
		end
	end

	// result register
	assign s_axis_tready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			m_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_data_q <= {3'b000, r_err, r_done, r_byte,
			             !((stage_nx == i2crm_pkg::STG_IDLE) && (step_nx == 3'd0)),
			             sda_nx, scl_nx};
			m_user_q <= r_valid;
			m_last_q <= r_last;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;
	assign m_axis_tlast    = m_last_q;

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while result stalled");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_last_q |-> m_user_q)
		else $error("read_last without read_valid");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[12] |-> m_data_q[11])
		else $error("error flag without done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[11] |-> !m_data_q[2] && idle)
		else $error("done reported while still busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_user_q |-> stage_q == i2crm_pkg::STG_RECV && rmode_q)
		else $error("read byte outside receive stage");

endmodule
